>>> sv/tvs_pkg.sv
// Shared types and constants for the trilinear voxel sampler.
// No dependencies; imported by trilinear_voxel_sampler.
`default_nettype none
package tvs_pkg;

	localparam int DEF_MAX_CELLS  = 4096;
	localparam int DEF_VALUE_BITS = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X         = 3'd0,
		REG_SIZE_Y         = 3'd1,
		REG_SIZE_Z         = 3'd2,
		REG_THREE_CHANNELS = 3'd3,
		REG_BOX_ORIGIN     = 3'd4,
		REG_CELLS_PER_UNIT = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef struct packed {
		logic               action;
		logic [13:0]        element_index;
		logic [15:0]        element_value;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
	} item_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} result_t;

endpackage
`default_nettype wire

>>> sv/trilinear_voxel_sampler.sv
// Voxel grid sampler: cell store in one single-port memory, trilinear blend.
// Depends on tvs_pkg for item, result and register index types.
//
//  channel   signals                             beat taken when
//  item      start, busy, item                   start && !busy
//  result    done, result                        done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index,    cfg_valid && cfg_ready
//            cfg_data
//
// A load leaves busy low; the next item is accepted in the following cycle.
// A sample holds busy after its accept while the eight corner cells are read,
// one store read per cycle; the next item is accepted once busy falls.
// The result strobes after the last corner is blended along x, y and z.
// Reset clears control and config registers; data and store are not reset.
`default_nettype none
module trilinear_voxel_sampler #(
	parameter int MAX_CELLS  = tvs_pkg::DEF_MAX_CELLS,
	parameter int VALUE_BITS = tvs_pkg::DEF_VALUE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire tvs_pkg::item_t                item,
	output      logic                          done,
	output      tvs_pkg::result_t              result,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tvs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tvs_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	// configuration
	logic [8:0]  size_q [3];
	logic        three_q;
	logic [47:0] origin_q, scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= 9'd1;
			size_q[1] <= 9'd1;
			size_q[2] <= 9'd1;
			three_q   <= 1'b0;
			origin_q  <= '0;
			scale_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SIZE_X:         size_q[0] <= cfg_data[8:0];
				REG_SIZE_Y:         size_q[1] <= cfg_data[8:0];
				REG_SIZE_Z:         size_q[2] <= cfg_data[8:0];
				REG_THREE_CHANNELS: three_q   <= cfg_data[0];
				REG_BOX_ORIGIN:     origin_q  <= cfg_data;
				REG_CELLS_PER_UNIT: scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// accept and position mapping
	logic accept;
	logic issuing_q;
	logic [2:0] cnt_q;

	assign busy   = issuing_q;
	assign accept = start && !busy;

	logic signed [15:0] pos [3];
	logic signed [16:0] diff [3];
	logic signed [33:0] tmap [3];

	assign pos[0] = item.pos_x;
	assign pos[1] = item.pos_y;
	assign pos[2] = item.pos_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = {pos[a][15], pos[a]} - {origin_q[16*a+15], origin_q[16*a +: 16]};
			tmap[a] = diff[a] * $signed({1'b0, scale_q[16*a +: 16]}) - 34'sd32768;
		end
	end

	logic signed [17:0] cell_q [3];
	logic [15:0]        frac_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			cnt_q     <= '0;
		end else if (accept && item.action == ACT_SAMPLE) begin
			issuing_q <= 1'b1;
			cnt_q     <= '0;
		end else if (issuing_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7)
				issuing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.action == ACT_SAMPLE) begin
			for (int a = 0; a < 3; a++) begin
				cell_q[a] <= tmap[a][33:16];
				frac_q[a] <= tmap[a][15:0];
			end
		end
	end

	// load addressing: divide by three through a reciprocal
	logic [28:0] recip;
	logic [12:0] quot;
	logic [13:0] rem;
	logic [13:0] ld_cell;
	logic [1:0]  ld_lane;

	assign recip   = 29'(item.element_index) * 29'd21846;
	assign quot    = recip[28:16];
	assign rem     = item.element_index - 14'({quot, 1'b0}) - 14'(quot);
	assign ld_cell = three_q ? 14'(quot) : item.element_index;
	assign ld_lane = three_q ? rem[1:0] : 2'd0;

	// corner issue
	logic signed [18:0] corner [3];
	logic [2:0]         c_in;
	logic [17:0]        zy;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			corner[a] = {cell_q[a][17], cell_q[a]} + 19'(cnt_q[a]);
			c_in[a]   = !corner[a][18] && (corner[a][17:0] < 18'(size_q[a]));
		end
		zy = 18'(corner[2][8:0]) * 18'(size_q[1]) + 18'(corner[1][8:0]);
	end

	// stage 1: store access
	logic          rd_s1, wr_s1;
	logic          in_s1;
	logic [17:0]   zy_s1;
	logic [8:0]    x_s1;
	logic [2:0]    k_s1;
	logic [15:0]   f_s1 [3];
	logic [AW-1:0] waddr_s1;
	logic [1:0]    wlane_s1;
	logic [VB-1:0] wval_s1;
	logic          wok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			rd_s1 <= issuing_q;
			wr_s1 <= accept && item.action == ACT_LOAD;
		end
	end

	always_ff @(posedge clk) begin
		in_s1    <= &c_in;
		zy_s1    <= zy;
		x_s1     <= corner[0][8:0];
		k_s1     <= cnt_q;
		f_s1     <= frac_q;
		waddr_s1 <= AW'(ld_cell);
		wlane_s1 <= ld_lane;
		wval_s1  <= VB'(item.element_value);
		wok_s1   <= 17'(ld_cell) < 17'(MAX_CELLS);
	end

	logic [26:0] flat;
	logic        hit;

	assign flat = 27'(zy_s1) * 27'(size_q[0]) + 27'(x_s1);
	assign hit  = in_s1 && (flat < 27'(MAX_CELLS));

	logic [3*VB-1:0] mem [MAX_CELLS];
	logic [3*VB-1:0] rdata_s2;

	always_ff @(posedge clk) begin
		if (wr_s1 && wok_s1)
			mem[waddr_s1][wlane_s1*VB +: VB] <= wval_s1;
		if (rd_s1)
			rdata_s2 <= mem[flat[AW-1:0]];
	end

	// stage 2: blend along x
	logic        rv_s2;
	logic        hit_s2;
	logic [2:0]  k_s2;
	logic [15:0] f_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rv_s2 <= 1'b0;
		else
			rv_s2 <= rd_s1;
	end

	always_ff @(posedge clk) begin
		hit_s2 <= hit;
		k_s2   <= k_s1;
		f_s2   <= f_s1;
	end

	function automatic logic [VB-1:0] lerp(input logic [VB-1:0] a, input logic [VB-1:0] b,
			input logic [15:0] w);
		logic [VB+17:0] s;
		s = (VB+18)'(a) * (VB+18)'(17'h10000 - {1'b0, w})
			+ (VB+18)'(b) * (VB+18)'(w) + (VB+18)'(32768);
		return s[VB+15:16];
	endfunction

	logic [VB-1:0] val [3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (!hit_s2)
				val[c] = '0;
			else if (three_q)
				val[c] = rdata_s2[c*VB +: VB];
			else
				val[c] = rdata_s2[VB-1:0];
		end
	end

	logic [VB-1:0] xa_q [3];
	logic          dv_s3;
	logic [1:0]    k_s3;
	logic [VB-1:0] dx_s3 [3];
	logic [15:0]   fy_s3, fz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_s3 <= 1'b0;
		else
			dv_s3 <= rv_s2 && k_s2[0];
	end

	always_ff @(posedge clk) begin
		if (rv_s2 && !k_s2[0])
			xa_q <= val;
		for (int c = 0; c < 3; c++)
			dx_s3[c] <= lerp(xa_q[c], val[c], f_s2[0]);
		k_s3  <= k_s2[2:1];
		fy_s3 <= f_s2[1];
		fz_s3 <= f_s2[2];
	end

	// stage 3: blend along y
	logic [VB-1:0] ya_q [3];
	logic          yv_s4;
	logic          k_s4;
	logic [VB-1:0] dy_s4 [3];
	logic [15:0]   fz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			yv_s4 <= 1'b0;
		else
			yv_s4 <= dv_s3 && k_s3[0];
	end

	always_ff @(posedge clk) begin
		if (dv_s3 && !k_s3[0])
			ya_q <= dx_s3;
		for (int c = 0; c < 3; c++)
			dy_s4[c] <= lerp(ya_q[c], dx_s3[c], fy_s3);
		k_s4  <= k_s3[1];
		fz_s4 <= fz_s3;
	end

	// stage 4: blend along z, saturate
	logic [VB-1:0]  za_q [3];
	logic [VB-1:0]  dz [3];
	logic [VB+15:0] dzw [3];
	logic [15:0]    sat [3];
	logic           done_q;
	result_t        result_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dz[c]  = lerp(za_q[c], dy_s4[c], fz_s4);
			dzw[c] = (VB+16)'(dz[c]);
			sat[c] = (dzw[c] > (VB+16)'(65535)) ? 16'hFFFF : dzw[c][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= yv_s4 && k_s4;
	end

	always_ff @(posedge clk) begin
		if (yv_s4 && !k_s4)
			za_q <= dy_s4;
		result_q.red   <= sat[0];
		result_q.green <= sat[1];
		result_q.blue  <= sat[2];
	end

	assign done   = done_q;
	assign result = result_q;

	a_op_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_s1 && wr_s1))
		else $error("store read and write in one cycle");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.action == ACT_SAMPLE |=> busy && cnt_q == 3'd0)
		else $error("sample did not start corner issue");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 && !issuing_q |-> k_s1 == 3'd7)
		else $error("issue ended before the last corner");

	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(rd_s1 && k_s1 == 3'd7, 4))
		else $error("result without a finished corner read");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for trilinear_voxel_sampler: directed rows, then random loads and samples.
// Depends on tvs_pkg for the item, result and register index types.
`default_nettype none
module tb_top;
	import tvs_pkg::*;

	localparam int CELLS    = DEF_MAX_CELLS;
	localparam int WD_LIMIT = 2000;
	localparam int SETTLE   = 20;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	trilinear_voxel_sampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block's registers and cell store
	logic [8:0] grid_x, grid_y, grid_z;
	logic rgb_mode;
	logic [47:0] origin_r, scale_r;
	logic [15:0] voxel_lane [CELLS][3];
	bit lane_set [CELLS][3];

	result_t pending_rgb[$];
	int errors;
	int stall_cycles;
	bit quiet;

	typedef struct {
		item_t it;
		bit typed;
		result_t rgb;
	} row_t;
	row_t rows[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint axis_cell(input logic [15:0] p, input int ax,
		output longint frac);
		longint o, s, t;
		o = longint'($signed(origin_r[16*ax +: 16]));
		s = longint'({1'b0, scale_r[16*ax +: 16]});
		t = (longint'($signed(p)) - o) * s - 32768;
		frac = t & 64'hFFFF;
		return t >>> 16;
	endfunction

	function automatic longint cell_flat(input longint x, input longint y, input longint z);
		if (x < 0 || y < 0 || z < 0) return -1;
		if (x >= grid_x || y >= grid_y || z >= grid_z) return -1;
		return (z * grid_y + y) * grid_x + x;
	endfunction

	function automatic longint lane_at(input longint x, input longint y, input longint z,
		input int lane);
		longint f;
		f = cell_flat(x, y, z);
		if (f < 0 || f >= CELLS) return 0;
		return longint'(voxel_lane[f][lane]);
	endfunction

	function automatic longint lerp(input longint a, input longint b, input longint w);
		return (a * (65536 - w) + b * w + 32768) >>> 16;
	endfunction

	function automatic result_t blend_sample(input item_t it);
		longint fx, fy, fz, ix, iy, iz, v, d00, d10, d01, d11;
		longint ch [3];
		int lane;
		result_t r;
		ix = axis_cell(it.pos_x, 0, fx);
		iy = axis_cell(it.pos_y, 1, fy);
		iz = axis_cell(it.pos_z, 2, fz);
		for (int c = 0; c < 3; c++) begin
			lane = rgb_mode ? c : 0;
			d00 = lerp(lane_at(ix, iy, iz, lane), lane_at(ix + 1, iy, iz, lane), fx);
			d10 = lerp(lane_at(ix, iy + 1, iz, lane), lane_at(ix + 1, iy + 1, iz, lane), fx);
			d01 = lerp(lane_at(ix, iy, iz + 1, lane), lane_at(ix + 1, iy, iz + 1, lane), fx);
			d11 = lerp(lane_at(ix, iy + 1, iz + 1, lane),
				lane_at(ix + 1, iy + 1, iz + 1, lane), fx);
			v = lerp(lerp(d00, d10, fy), lerp(d01, d11, fy), fz);
			ch[c] = (v > 65535) ? 65535 : v;
		end
		r.red = ch[0][15:0];
		r.green = ch[1][15:0];
		r.blue = ch[2][15:0];
		return r;
	endfunction

	function automatic bit idle_now();
		return !quiet && ($urandom_range(0, 99) < 17);
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.action = action_t'($urandom_range(0, 1));
		it.element_index = 14'($urandom_range(0, 12287));
		it.element_value = 16'($urandom);
		it.pos_x = 16'($urandom);
		it.pos_y = 16'($urandom);
		it.pos_z = 16'($urandom);
		return it;
	endfunction

	// Drive one beat; on accept, update the store or queue the expected result.
	task automatic send_item(input item_t it, input bit typed, input result_t rgb);
		int cell_no, lane;
		while (idle_now()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (it.action == ACT_LOAD) begin
			cell_no = rgb_mode ? it.element_index / 3 : it.element_index;
			lane = rgb_mode ? it.element_index % 3 : 0;
			if (cell_no < CELLS) begin
				voxel_lane[cell_no][lane] = it.element_value;
				lane_set[cell_no][lane] = 1'b1;
			end
		end else begin
			pending_rgb.push_back(typed ? rgb : blend_sample(it));
		end
	endtask

	// Load every corner lane the sample will read that was never written, then sample.
	task automatic send_sample(input item_t it);
		longint fx, fy, fz, ix, iy, iz, f;
		item_t ld;
		ix = axis_cell(it.pos_x, 0, fx);
		iy = axis_cell(it.pos_y, 1, fy);
		iz = axis_cell(it.pos_z, 2, fz);
		for (int k = 0; k < 8; k++) begin
			f = cell_flat(ix + k[0], iy + k[1], iz + k[2]);
			if (f >= 0 && f < CELLS) begin
				for (int l = 0; l < (rgb_mode ? 3 : 1); l++) begin
					if (!lane_set[f][l]) begin
						ld = noise_item();
						ld.action = ACT_LOAD;
						ld.element_index = 14'(rgb_mode ? f * 3 + l : f);
						send_item(ld, 1'b0, '0);
					end
				end
			end
		end
		send_item(it, 1'b0, '0);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [47:0] v);
		while (idle_now()) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_SIZE_X: grid_x = v[8:0];
			REG_SIZE_Y: grid_y = v[8:0];
			REG_SIZE_Z: grid_z = v[8:0];
			REG_THREE_CHANNELS: rgb_mode = v[0];
			REG_BOX_ORIGIN: origin_r = v;
			REG_CELLS_PER_UNIT: scale_r = v;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_rgb.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [8:0] sx, input logic [8:0] sy, input logic [8:0] sz,
		input bit ch3, input logic [47:0] org, input logic [47:0] scl);
		start <= 1'b0;
		drain();
		write_reg(REG_SIZE_X, 48'(sx));
		write_reg(REG_SIZE_Y, 48'(sy));
		write_reg(REG_SIZE_Z, 48'(sz));
		write_reg(REG_THREE_CHANNELS, 48'(ch3));
		write_reg(REG_BOX_ORIGIN, org);
		write_reg(REG_CELLS_PER_UNIT, scl);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(0, 4))
			0: return 16'h0100;
			1: return 16'h0080;
			2: return 16'h0200;
			3: return 16'h0180;
			default: return 16'($urandom);
		endcase
	endfunction

	// Aim a position at a random cell near the grid along one axis.
	function automatic logic [15:0] aim_axis(input int ax, input int span);
		longint c, s, d;
		c = longint'($urandom_range(0, span + 2)) - 1;
		s = longint'({1'b0, scale_r[16*ax +: 16]});
		if (s == 0) return 16'($urandom);
		d = (c * 65536 + longint'($urandom_range(0, 65535)) + 32768) / s;
		return 16'(longint'($signed(origin_r[16*ax +: 16])) + d);
	endfunction

	function automatic void add_row(input action_t a, input int idx, input logic [15:0] val,
		input logic [15:0] p, input bit typed, input logic [15:0] v);
		row_t r;
		r.it.action = a;
		r.it.element_index = 14'(idx);
		r.it.element_value = val;
		r.it.pos_x = p;
		r.it.pos_y = ~p;
		r.it.pos_z = p;
		r.typed = typed;
		r.rgb = '{v, v, v};
		rows.push_back(r);
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rgb.size() == 0) begin
				$error("result with nothing expected: %h", result);
				errors++;
			end else begin
				result_t e;
				e = pending_rgb.pop_front();
				if (result.red !== e.red) begin
					$error("red: expected %h, got %h", e.red, result.red);
					errors++;
				end
				if (result.green !== e.green) begin
					$error("green: expected %h, got %h", e.green, result.green);
					errors++;
				end
				if (result.blue !== e.blue) begin
					$error("blue: expected %h, got %h", e.blue, result.blue);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles in which no beat moves on any channel
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WD_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		item_t it;
		logic [8:0] sx, sy, sz;
		bit ch3;
		logic [47:0] org, scl;
		errors = 0;
		quiet = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		grid_x = 1; grid_y = 1; grid_z = 1;
		rgb_mode = 0;
		origin_r = '0;
		scale_r = '0;
		foreach (lane_set[i, j]) lane_set[i][j] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: one cell, zero scale, so every sample lands half a cell off
		add_row(ACT_LOAD, 0, 16'h0000, 16'h8000, 0, 0);
		add_row(ACT_SAMPLE, 12287, 16'hFFFF, 16'h0000, 1, 16'h0000);
		add_row(ACT_LOAD, 0, 16'hFFFF, 16'h7FFF, 0, 0);
		add_row(ACT_SAMPLE, 0, 16'h0000, 16'h7FFF, 1, 16'd8192);
		add_row(ACT_SAMPLE, 0, 16'h0000, 16'h8000, 1, 16'd8192);
		// loads past the store are dropped
		add_row(ACT_LOAD, 4096, 16'h1234, 16'h0000, 0, 0);
		add_row(ACT_LOAD, 12287, 16'h0000, 16'hFFFF, 0, 0);
		add_row(ACT_SAMPLE, 4096, 16'h5555, 16'hFFFF, 1, 16'd8192);
		add_row(ACT_LOAD, 4095, 16'hFFFF, 16'h0001, 0, 0);
		add_row(ACT_LOAD, 0, 16'h0001, 16'h0000, 0, 0);
		add_row(ACT_SAMPLE, 8191, 16'hAAAA, 16'h0100, 0, 0);
		add_row(ACT_LOAD, 0, 16'h8000, 16'h0000, 0, 0);
		add_row(ACT_SAMPLE, 0, 16'h0000, 16'h0000, 0, 0);
		foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].rgb);

		for (int ph = 0; ph < 8; ph++) begin
			ch3 = ph[0];
			org = {16'($urandom), 16'($urandom), 16'($urandom)};
			scl = {pick_scale(), pick_scale(), pick_scale()};
			case (ph)
				0: begin sx = 4; sy = 4; sz = 4; scl = {3{16'h0100}}; end
				1: begin sx = 16; sy = 16; sz = 16; end
				2: begin sx = 0; sy = 5; sz = 7; end
				3: begin sx = 511; sy = 511; sz = 511; org = '0; end
				4: begin sx = 256; sy = 256; sz = 256; org = {3{16'h7FFF}};
					scl = {3{16'hFFFF}}; end
				5: begin sx = 1; sy = 1; sz = 1; org = {3{16'h8000}}; scl = '0; end
				default: begin
					sx = $urandom_range(1, 20);
					sy = $urandom_range(1, 20);
					sz = $urandom_range(1, 20);
				end
			endcase
			configure(sx, sy, sz, ch3, org, scl);
			quiet = (ph == 3);
			for (int n = 0; n < 220; n++) begin
				it = noise_item();
				if ($urandom_range(0, 9) < 6) begin
					it.action = ACT_SAMPLE;
					if ($urandom_range(0, 4) != 0) begin
						it.pos_x = aim_axis(0, (sx > 24) ? 24 : sx);
						it.pos_y = aim_axis(1, (sy > 24) ? 24 : sy);
						it.pos_z = aim_axis(2, (sz > 24) ? 24 : sz);
					end
					send_sample(it);
				end else begin
					it.action = ACT_LOAD;
					send_item(it, 1'b0, '0);
				end
			end
			quiet = 0;
		end
		start <= 1'b0;
		drain();

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
